FILE: hdl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types, codes and helpers of the I2C/SCCB master status sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int unsigned DEFAULT_BUFFER_DEPTH = 32;
  localparam int unsigned CNT_W = 6;

  // Item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_SCCB_MODE    = 2'd0;
  localparam logic [1:0] CFG_WRITE_LENGTH = 2'd1;
  localparam logic [1:0] CFG_READ_LENGTH  = 2'd2;

  // Bus status codes reported by the serial engine
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_REP_START    = 8'h10;
  localparam logic [7:0] ST_ADDR_W_ACK   = 8'h18;
  localparam logic [7:0] ST_ADDR_W_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK   = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK  = 8'h30;
  localparam logic [7:0] ST_ARB_LOST     = 8'h38;
  localparam logic [7:0] ST_ADDR_R_ACK   = 8'h40;
  localparam logic [7:0] ST_ADDR_R_NACK  = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK   = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK  = 8'h58;

  // Start and acknowledge actions
  localparam logic [1:0] START_NONE   = 2'd0;
  localparam logic [1:0] START_REPEAT = 2'd1;
  localparam logic [1:0] START_CLEAR  = 2'd2;

  localparam logic [1:0] ACK_KEEP    = 2'd0;
  localparam logic [1:0] ACK_ENABLE  = 2'd1;
  localparam logic [1:0] ACK_DISABLE = 2'd2;

  typedef struct packed {
    logic       send_valid;
    logic [1:0] start_action;
    logic       stop_request;
    logic [1:0] ack_action;
    logic [2:0] transfer_status;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [4:0] read_position;
    logic       unknown_status;
  } result_t;

  // Wrap a 5-bit buffer index into the buffer depth (depth of at least 4)
  function automatic logic [7:0] wrap_index(input logic [4:0] idx,
                                            input int unsigned depth);
    logic [8:0] v;
    v = {4'd0, idx};
    for (int i = 0; i < 8; i++) begin
      if (v >= 9'(depth)) begin
        v = v - 9'(depth);
      end
    end
    return v[7:0];
  endfunction

endpackage

FILE: hdl/i2cms_ram.sv
// ----------------------------------------------------------------------------
// i2cms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2cms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/i2cms_ctrl.sv
// ----------------------------------------------------------------------------
// i2cms_ctrl
// Status code decode, send/receive counters and transfer phase.
// ----------------------------------------------------------------------------
module i2cms_ctrl
  import i2cms_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic                            kind,
  input  logic [4:0]                      load_index,
  input  logic [7:0]                      status_code,
  input  logic [7:0]                      received_byte,
  input  logic                            sccb_mode,
  input  logic [CNT_W-1:0]                write_length,
  input  logic [CNT_W-1:0]                read_length,
  output result_t                         result,
  output logic                            wr_en,
  output logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
  output logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);
  localparam logic [AW-1:0] ONE_ADDR  = AW'(1);
  localparam logic [CNT_W-1:0] CNT_SAT = '1;
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_PENDING, PH_DONE, PH_DATA_NACK, PH_ADDR_NACK, PH_ARB_LOST
  } phase_t;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] send_cnt, send_cnt_next, send_cnt_inc;
  logic [AW-1:0]    send_addr, send_addr_next, send_addr_inc;
  logic [CNT_W-1:0] recv_cnt, recv_cnt_next, recv_cnt_inc;
  logic [AW-1:0]    recv_addr, recv_addr_next, recv_addr_inc;
  logic [7:0]       load_wrapped;
  logic [7:0]       recv_addr_wide;
  logic             do_emit, do_after_data, do_take;

  // Counts saturate at 63; the buffer address follows the count modulo depth
  assign send_cnt_inc  = (send_cnt == CNT_SAT) ? send_cnt : send_cnt + CNT_ONE;
  assign send_addr_inc = (send_cnt == CNT_SAT) ? send_addr :
                         (send_addr == LAST_ADDR) ? '0 : send_addr + ONE_ADDR;
  assign recv_cnt_inc  = (recv_cnt == CNT_SAT) ? recv_cnt : recv_cnt + CNT_ONE;
  assign recv_addr_inc = (recv_cnt == CNT_SAT) ? recv_addr :
                         (recv_addr == LAST_ADDR) ? '0 : recv_addr + ONE_ADDR;

  assign load_wrapped   = wrap_index(load_index, BUFFER_DEPTH);
  assign wr_addr        = load_wrapped[AW-1:0];
  assign wr_en          = advance && (kind == KIND_LOAD);
  assign recv_addr_wide = 8'(recv_addr);

  always_comb begin
    result         = '0;
    phase_next     = phase;
    send_cnt_next  = send_cnt;
    send_addr_next = send_addr;
    recv_cnt_next  = recv_cnt;
    recv_addr_next = recv_addr;
    rd_addr        = send_addr;
    do_emit        = 1'b0;
    do_after_data  = 1'b0;
    do_take        = 1'b0;

    if (kind == KIND_EVENT) begin
      case (status_code)
        ST_START: begin
          // restart both counts, first byte comes from position zero
          rd_addr             = '0;
          result.send_valid   = 1'b1;
          send_cnt_next       = CNT_ONE;
          send_addr_next      = ONE_ADDR;
          recv_cnt_next       = '0;
          recv_addr_next      = '0;
          phase_next          = PH_PENDING;
          result.start_action = START_CLEAR;
        end
        ST_REP_START: begin
          recv_cnt_next       = '0;
          recv_addr_next      = '0;
          do_emit             = 1'b1;
          result.start_action = START_CLEAR;
        end
        ST_ADDR_W_ACK: do_emit = 1'b1;
        ST_ADDR_W_NACK: begin
          if (sccb_mode) begin
            do_emit = 1'b1;
          end else begin
            result.stop_request = 1'b1;
            phase_next          = PH_ADDR_NACK;
          end
        end
        ST_DATA_W_ACK: do_after_data = 1'b1;
        ST_DATA_W_NACK: begin
          if (sccb_mode) begin
            do_after_data = 1'b1;
          end else begin
            result.stop_request = 1'b1;
            phase_next          = PH_DATA_NACK;
          end
        end
        ST_ARB_LOST: phase_next = PH_ARB_LOST;
        ST_ADDR_R_ACK: begin
          result.ack_action = (read_length == CNT_W'(1)) ? ACK_DISABLE : ACK_ENABLE;
        end
        ST_ADDR_R_NACK: begin
          result.stop_request = 1'b1;
          phase_next          = PH_ADDR_NACK;
        end
        ST_DATA_R_ACK: begin
          do_take = 1'b1;
          // last-byte rule on the count after this byte
          result.ack_action = ((7'(recv_cnt_inc) + 7'd1) < 7'(read_length)) ?
                              ACK_ENABLE : ACK_DISABLE;
        end
        ST_DATA_R_NACK: begin
          do_take             = 1'b1;
          phase_next          = PH_DONE;
          result.stop_request = 1'b1;
        end
        default: begin
          result.stop_request   = 1'b1;
          result.unknown_status = 1'b1;
        end
      endcase
    end

    if (do_after_data) begin
      if (send_cnt < write_length) begin
        do_emit = 1'b1;
      end else if (read_length != '0) begin
        result.start_action = START_REPEAT;
      end else begin
        phase_next          = PH_DONE;
        result.stop_request = 1'b1;
      end
    end

    if (do_emit) begin
      result.send_valid = 1'b1;
      send_cnt_next     = send_cnt_inc;
      send_addr_next    = send_addr_inc;
    end

    if (do_take) begin
      result.read_valid    = 1'b1;
      result.read_byte     = received_byte;
      result.read_position = recv_addr_wide[4:0];
      recv_cnt_next        = recv_cnt_inc;
      recv_addr_next       = recv_addr_inc;
    end

    result.transfer_status = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      send_cnt  <= '0;
      send_addr <= '0;
      recv_cnt  <= '0;
      recv_addr <= '0;
    end else if (advance) begin
      phase     <= phase_next;
      send_cnt  <= send_cnt_next;
      send_addr <= send_addr_next;
      recv_cnt  <= recv_cnt_next;
      recv_addr <= recv_addr_next;
    end
  end

  // An unhandled code leaves the transfer phase alone
  assert property (@(posedge clk) disable iff (rst)
    (advance && result.unknown_status) |=> (phase == $past(phase)))
    else $error("phase changed on unknown status code");

  // A start event leaves exactly one byte sent
  assert property (@(posedge clk) disable iff (rst)
    (advance && kind == KIND_EVENT && status_code == ST_START) |=>
      (send_cnt == CNT_ONE && send_addr == ONE_ADDR && recv_cnt == '0))
    else $error("counters wrong after start event");

  // Buffer addresses stay inside the buffer
  assert property (@(posedge clk) disable iff (rst)
    (32'(send_addr) < BUFFER_DEPTH) && (32'(recv_addr) < BUFFER_DEPTH))
    else $error("buffer address out of range");

endmodule

FILE: hdl/i2c_master_status_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_status_sequencer
// Master-side I2C/SCCB transfer sequencer, one bus event or buffer load per item.
// ----------------------------------------------------------------------------
// The input register holds each accepted item, then decode and the buffer read
//   load the result register.
// Throughput: one item per cycle while the result register is not stalled; the
//   buffer RAM's registered read port sets the second stage.
// Reset clears the pipeline, counters and phase, turns SCCB mode on and zeroes
//   both lengths; the outgoing buffer is not cleared.
module i2c_master_status_sequencer
  import i2cms_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [4:0] load_index,
  input  logic [7:0] load_byte,
  input  logic [7:0] status_code,
  input  logic [7:0] received_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       send_valid,
  output logic [7:0] send_byte,
  output logic [1:0] start_action,
  output logic       stop_request,
  output logic [1:0] ack_action,
  output logic [2:0] transfer_status,
  output logic       read_valid,
  output logic [7:0] read_byte,
  output logic [4:0] read_position,
  output logic       unknown_status
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  logic             sccb_mode;
  logic [CNT_W-1:0] write_length, read_length;

  logic       s1_valid;
  logic       s1_kind;
  logic [4:0] s1_load_index;
  logic [7:0] s1_load_byte, s1_status_code, s1_received_byte;

  logic          advance, in_accept;
  result_t       res_next, res;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    rd_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sccb_mode    <= 1'b1;
      write_length <= '0;
      read_length  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCCB_MODE:    sccb_mode    <= cfg_data[0];
        CFG_WRITE_LENGTH: write_length <= cfg_data;
        CFG_READ_LENGTH:  read_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1 moves on when the result register is free or being emptied
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind          <= kind;
      s1_load_index    <= load_index;
      s1_load_byte     <= load_byte;
      s1_status_code   <= status_code;
      s1_received_byte <= received_byte;
    end
  end

  i2cms_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .kind         (s1_kind),
    .load_index   (s1_load_index),
    .status_code  (s1_status_code),
    .received_byte(s1_received_byte),
    .sccb_mode    (sccb_mode),
    .write_length (write_length),
    .read_length  (read_length),
    .result       (res_next),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .rd_addr      (rd_addr)
  );

  i2cms_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_buffer (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(s1_load_byte),
    .rd_en  (advance),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign send_valid      = res.send_valid;
  assign send_byte       = res.send_valid ? rd_data : 8'd0;
  assign start_action    = res.start_action;
  assign stop_request    = res.stop_request;
  assign ack_action      = res.ack_action;
  assign transfer_status = res.transfer_status;
  assign read_valid      = res.read_valid;
  assign read_byte       = res.read_byte;
  assign read_position   = res.read_position;
  assign unknown_status  = res.unknown_status;

  // Every item leaving stage 1 shows up as a result
  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("item lost between stages");

  // An empty input stage never holds off the source
  assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("stall raised with empty input stage");

  // Hold a stalled result item unchanged
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(res) && $stable(rd_data)))
    else $error("stalled result item changed");

endmodule

FILE: tb/i2cms_seq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_seq_checker
// Watches the configuration, item and result channels of the I2C/SCCB master
// status sequencer, predicts the result of every accepted item and compares
// each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module i2cms_seq_checker
  import i2cms_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       kind,
  input  logic [4:0] load_index,
  input  logic [7:0] load_byte,
  input  logic [7:0] status_code,
  input  logic [7:0] received_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       send_valid,
  input  logic [7:0] send_byte,
  input  logic [1:0] start_action,
  input  logic       stop_request,
  input  logic [1:0] ack_action,
  input  logic [2:0] transfer_status,
  input  logic       read_valid,
  input  logic [7:0] read_byte,
  input  logic [4:0] read_position,
  input  logic       unknown_status,
  output int         fail_count,
  output int         pending_results
);

  // Transfer phases as reported on transfer_status
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_PENDING   = 3'd1;
  localparam logic [2:0] PH_DONE      = 3'd2;
  localparam logic [2:0] PH_DATA_NACK = 3'd3;
  localparam logic [2:0] PH_ADDR_NACK = 3'd4;
  localparam logic [2:0] PH_ARB_LOST  = 3'd5;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic [1:0] start_action;
    logic       stop_request;
    logic [1:0] ack_action;
    logic [2:0] transfer_status;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [4:0] read_position;
    logic       unknown_status;
  } seq_result_t;

  logic [7:0]  tx_buf [BUFFER_DEPTH];
  logic [5:0]  tx_count;
  logic [5:0]  rx_count;
  logic [2:0]  phase;
  logic        sccb_on;
  logic [5:0]  wr_len;
  logic [5:0]  rd_len;

  seq_result_t expected_results[$];
  int          fails = 0;

  function automatic logic [5:0] sat_inc(input logic [5:0] c);
    return (c == 6'd63) ? c : c + 6'd1;
  endfunction

  task automatic hand_out_byte(inout seq_result_t r);
    r.send_valid = 1'b1;
    r.send_byte  = tx_buf[tx_count % BUFFER_DEPTH];
    tx_count     = sat_inc(tx_count);
  endtask

  // next step once a data byte has gone out
  task automatic after_write_byte(inout seq_result_t r);
    if (tx_count < wr_len) begin
      hand_out_byte(r);
    end else if (rd_len != 6'd0) begin
      r.start_action = START_REPEAT;
    end else begin
      phase          = PH_DONE;
      r.stop_request = 1'b1;
    end
  endtask

  task automatic take_rx_byte(inout seq_result_t r, input logic [7:0] rx);
    r.read_valid    = 1'b1;
    r.read_byte     = rx;
    r.read_position = 5'(rx_count % BUFFER_DEPTH);
    rx_count        = sat_inc(rx_count);
  endtask

  task automatic predict_sequencer_step(input logic k, input logic [4:0] li,
                                        input logic [7:0] lb, input logic [7:0] sc,
                                        input logic [7:0] rx, output seq_result_t r);
    r = '0;
    if (k == KIND_LOAD) begin
      tx_buf[li % BUFFER_DEPTH] = lb;
    end else begin
      case (sc)
        ST_START: begin
          tx_count = '0;
          rx_count = '0;
          hand_out_byte(r);
          phase = PH_PENDING;
          r.start_action = START_CLEAR;
        end
        ST_REP_START: begin
          rx_count = '0;
          hand_out_byte(r);
          r.start_action = START_CLEAR;
        end
        ST_ADDR_W_ACK: hand_out_byte(r);
        ST_ADDR_W_NACK: begin
          if (sccb_on) begin
            hand_out_byte(r);
          end else begin
            r.stop_request = 1'b1;
            phase = PH_ADDR_NACK;
          end
        end
        ST_DATA_W_ACK: after_write_byte(r);
        ST_DATA_W_NACK: begin
          if (sccb_on) begin
            after_write_byte(r);
          end else begin
            r.stop_request = 1'b1;
            phase = PH_DATA_NACK;
          end
        end
        ST_ARB_LOST: phase = PH_ARB_LOST;
        ST_ADDR_R_ACK: r.ack_action = (rd_len == 6'd1) ? ACK_DISABLE : ACK_ENABLE;
        ST_ADDR_R_NACK: begin
          r.stop_request = 1'b1;
          phase = PH_ADDR_NACK;
        end
        ST_DATA_R_ACK: begin
          take_rx_byte(r, rx);
          // last-byte rule: disable acknowledge ahead of the final byte
          r.ack_action = (int'(rx_count) + 1 < int'(rd_len)) ? ACK_ENABLE : ACK_DISABLE;
        end
        ST_DATA_R_NACK: begin
          take_rx_byte(r, rx);
          phase = PH_DONE;
          r.stop_request = 1'b1;
        end
        default: begin
          r.stop_request   = 1'b1;
          r.unknown_status = 1'b1;
        end
      endcase
    end
    r.transfer_status = phase;
  endtask

  function automatic int field_bad(input string name, input int unsigned want,
                                   input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    seq_result_t want;
    seq_result_t fresh;
    if (rst) begin
      tx_count = '0;
      rx_count = '0;
      phase    = PH_IDLE;
      sccb_on  = 1'b1;
      wr_len   = '0;
      rd_len   = '0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCCB_MODE:    sccb_on = cfg_data[0];
          CFG_WRITE_LENGTH: wr_len  = cfg_data;
          CFG_READ_LENGTH:  rd_len  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result item with no prediction waiting");
          fails++;
        end else begin
          want = expected_results.pop_front();
          fails += field_bad("send_valid", want.send_valid, send_valid);
          fails += field_bad("send_byte", want.send_byte, send_byte);
          fails += field_bad("start_action", want.start_action, start_action);
          fails += field_bad("stop_request", want.stop_request, stop_request);
          fails += field_bad("ack_action", want.ack_action, ack_action);
          fails += field_bad("transfer_status", want.transfer_status, transfer_status);
          fails += field_bad("read_valid", want.read_valid, read_valid);
          fails += field_bad("read_byte", want.read_byte, read_byte);
          fails += field_bad("read_position", want.read_position, read_position);
          fails += field_bad("unknown_status", want.unknown_status, unknown_status);
        end
      end
      if (in_valid && !in_stall) begin
        predict_sequencer_step(kind, load_index, load_byte, status_code, received_byte,
                               fresh);
        expected_results.push_back(fresh);
      end
    end
    fail_count      <= fails;
    pending_results <= expected_results.size();
  end

endmodule

FILE: tb/tb_i2c_master_status_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_status_sequencer
// Drives buffer loads and bus status events into the sequencer: a preload of
// the outgoing buffer, two short directed sets, then random transfers with noise
// under several register settings and idling patterns. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_i2c_master_status_sequencer;
  import i2cms_pkg::*;

  localparam int unsigned DEPTH        = DEFAULT_BUFFER_DEPTH;
  localparam int          NUM_PHASES   = 8;
  localparam int          PHASE_ITEMS  = 100;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 20;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [5:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic       kind;
  logic [4:0] load_index;
  logic [7:0] load_byte;
  logic [7:0] status_code;
  logic [7:0] received_byte;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       send_valid;
  logic [7:0] send_byte;
  logic [1:0] start_action;
  logic       stop_request;
  logic [1:0] ack_action;
  logic [2:0] transfer_status;
  logic       read_valid;
  logic [7:0] read_byte;
  logic [4:0] read_position;
  logic       unknown_status;

  int fail_count;
  int pending_results;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int cycles        = 0;
  int cur_wlen      = 0;
  int cur_rlen      = 0;

  // register settings of the random phases
  int ph_sccb [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 1, 1};
  int ph_wlen [NUM_PHASES] = '{4, 0, 32, 63, 1, 2, 63, 3};
  int ph_rlen [NUM_PHASES] = '{2, 0, 32, 63, 1, 0, 0, 5};

  i2c_master_status_sequencer #(.BUFFER_DEPTH(DEPTH)) DUT (.*);

  i2cms_seq_checker #(.BUFFER_DEPTH(DEPTH)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic push_item(input logic k, input logic [4:0] li, input logic [7:0] lb,
                           input logic [7:0] sc, input logic [7:0] rx);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    load_index    <= li;
    load_byte     <= lb;
    status_code   <= sc;
    received_byte <= rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic push_event(input logic [7:0] sc);
    push_item(KIND_EVENT, 5'($urandom), 8'($urandom), sc, 8'($urandom));
  endtask

  task automatic push_load(input logic [4:0] li, input logic [7:0] lb);
    push_item(KIND_LOAD, li, lb, 8'($urandom), 8'($urandom));
  endtask

  // drop valid and let every predicted result drain
  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input int sccb, input int wlen, input int rlen);
    write_reg(CFG_SCCB_MODE, 6'(sccb));
    write_reg(CFG_WRITE_LENGTH, 6'(wlen));
    write_reg(CFG_READ_LENGTH, 6'(rlen));
    cur_wlen = wlen;
    cur_rlen = rlen;
  endtask

  function automatic logic [7:0] mostly(input logic [7:0] good, input logic [7:0] bad);
    return ($urandom_range(0, 9) != 0) ? good : bad;
  endfunction

  // one well-formed transfer with random content and the odd fault
  task automatic run_transfer();
    int n;
    push_event(ST_START);
    if ($urandom_range(0, 19) == 0) begin
      push_event(ST_ARB_LOST);
      return;
    end
    push_event(mostly(ST_ADDR_W_ACK, ST_ADDR_W_NACK));
    n = $urandom_range(0, cur_wlen);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) push_load(5'($urandom), 8'($urandom));
      push_event(mostly(ST_DATA_W_ACK, ST_DATA_W_NACK));
    end
    if (cur_rlen != 0 || $urandom_range(0, 1) == 1) begin
      push_event(ST_REP_START);
      push_event(mostly(ST_ADDR_R_ACK, ST_ADDR_R_NACK));
      n = (cur_rlen == 0) ? $urandom_range(0, 2) : $urandom_range(0, cur_rlen - 1);
      repeat (n) push_event(ST_DATA_R_ACK);
      push_event(ST_DATA_R_NACK);
    end
  endtask

  initial begin
    int start_count;
    int pick;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    kind          = KIND_LOAD;
    load_index    = '0;
    load_byte     = '0;
    status_code   = '0;
    received_byte = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 23;
    recv_idle_pct = 53;

    // fill the whole buffer so no event ever reads an unwritten entry
    for (int i = 0; i < int'(DEPTH); i++) push_load(5'(i), 8'($urandom));

    // directed: strict I2C, every code, both acknowledge faults, unknown codes
    go_quiet();
    apply_settings(0, 3, 2);
    push_load(5'd0, 8'h00);
    push_load(5'd31, 8'hFF);
    push_event(ST_START);
    push_event(ST_ADDR_W_ACK);
    push_event(ST_DATA_W_ACK);
    push_event(ST_DATA_W_ACK);
    push_event(ST_REP_START);
    push_event(ST_ADDR_R_ACK);
    push_item(KIND_EVENT, 5'd0, 8'h00, ST_DATA_R_ACK, 8'hFF);
    push_item(KIND_EVENT, 5'd31, 8'hFF, ST_DATA_R_NACK, 8'h00);
    push_event(ST_ADDR_W_NACK);
    push_event(ST_DATA_W_NACK);
    push_event(ST_ADDR_R_NACK);
    push_event(ST_ARB_LOST);
    push_event(8'h00);
    push_event(8'hFF);
    push_event(8'h09);

    // directed: SCCB tolerates missing acknowledge; read with zero read length
    go_quiet();
    apply_settings(1, 1, 0);
    push_event(ST_START);
    push_event(ST_ADDR_W_NACK);
    push_event(ST_DATA_W_NACK);
    push_event(ST_DATA_R_ACK);
    push_event(ST_DATA_R_NACK);

    for (int p = 0; p < NUM_PHASES; p++) begin
      go_quiet();
      if (p < 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 53;
      end else if (p < 6) begin
        send_idle_pct = 53;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_settings(ph_sccb[p], ph_wlen[p], ph_rlen[p]);
      start_count = items_sent;
      while (items_sent - start_count < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          run_transfer();
        end else if (pick < 85) begin
          push_load(5'($urandom), 8'($urandom));
        end else begin
          push_item(1'($urandom), 5'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
        end
      end
    end

    go_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/i2cms_pkg.sv
hdl/i2cms_ram.sv
hdl/i2cms_ctrl.sv
hdl/i2c_master_status_sequencer.sv
tb/i2cms_seq_checker.sv
tb/tb_i2c_master_status_sequencer.sv
